@@ design/dlbc_pkg.sv @@
// ----------------------------------------------------------------------------
// dlbc_pkg
// Shared widths and codes for the local block count unit.
// ----------------------------------------------------------------------------
package dlbc_pkg;

	// Field widths.
	localparam int RANK_W  = 31;
	localparam int GSIZE_W = 31;
	localparam int DARG_W  = 31;
	localparam int GRID_W  = 16;
	localparam int PROD_W  = 63;
	localparam int CYC_W   = DARG_W + GRID_W;

	// Serial multiplier: a (up to PROD_W bits) times b (up to GSIZE_W bits).
	localparam int MUL_A_W   = PROD_W;
	localparam int MUL_B_W   = GSIZE_W;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W);

	// Serial divider: 31-bit dividend over a divisor as wide as a cycle length.
	localparam int DIV_N_W   = GSIZE_W;
	localparam int DIV_D_W   = CYC_W;
	localparam int DIV_CNT_W = $clog2(DIV_N_W);

	// Configuration port.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [0:0] {
		REG_PROCESS_RANK = 1'b0
	} reg_idx_t;

endpackage

@@ design/dlbc_mul.sv @@
// ----------------------------------------------------------------------------
// dlbc_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module dlbc_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dlbc_pkg::MUL_A_W-1:0]  a,
	input  logic [dlbc_pkg::MUL_B_W-1:0]  b,
	output logic                          done,
	output logic [dlbc_pkg::MUL_P_W-1:0]  product
);

	logic                            busy_q;
	logic                            done_q;
	logic [dlbc_pkg::MUL_CNT_W-1:0]  cnt_q;
	logic [dlbc_pkg::MUL_A_W-1:0]    a_q;
	logic [dlbc_pkg::MUL_P_W-1:0]    acc_q;
	logic [dlbc_pkg::MUL_A_W:0]      sum;

	// The low end of the accumulator holds the multiplier bits still to use.
	assign sum = {1'b0, acc_q[dlbc_pkg::MUL_P_W-1:dlbc_pkg::MUL_B_W]}
		+ (acc_q[0] ? {1'b0, a_q} : {(dlbc_pkg::MUL_A_W+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == dlbc_pkg::MUL_CNT_W'(dlbc_pkg::MUL_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			acc_q <= {{dlbc_pkg::MUL_A_W{1'b0}}, b};
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[dlbc_pkg::MUL_B_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

@@ design/dlbc_div.sv @@
// ----------------------------------------------------------------------------
// dlbc_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dlbc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dlbc_pkg::DIV_N_W-1:0]  dividend,
	input  logic [dlbc_pkg::DIV_D_W-1:0]  divisor,
	output logic                          done,
	output logic [dlbc_pkg::DIV_N_W-1:0]  quotient,
	output logic [dlbc_pkg::DIV_N_W-1:0]  remainder
);

	logic                            busy_q;
	logic                            done_q;
	logic [dlbc_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [dlbc_pkg::DIV_N_W-1:0]    quot_q;
	logic [dlbc_pkg::DIV_N_W-1:0]    rem_q;
	logic [dlbc_pkg::DIV_D_W-1:0]    dvs_q;
	logic [dlbc_pkg::DIV_N_W:0]      trial;
	logic [dlbc_pkg::DIV_N_W:0]      diff;
	logic                            ge;

	// The partial remainder never exceeds the dividend prefix, so it stays narrow.
	assign trial = {rem_q, quot_q[dlbc_pkg::DIV_N_W-1]};
	assign ge    = {{(dlbc_pkg::DIV_D_W-dlbc_pkg::DIV_N_W-1){1'b0}}, trial} >= dvs_q;
	assign diff  = trial - dvs_q[dlbc_pkg::DIV_N_W:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == dlbc_pkg::DIV_CNT_W'(dlbc_pkg::DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[dlbc_pkg::DIV_N_W-2:0], ge};
			rem_q  <= ge ? diff[dlbc_pkg::DIV_N_W-1:0] : trial[dlbc_pkg::DIV_N_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quot_q;
	assign remainder = rem_q;

endmodule

@@ design/darray_local_block_count_unit.sv @@
// ----------------------------------------------------------------------------
// darray_local_block_count_unit
// Counts the elements one process owns of a block/cyclic distributed array.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | global_size, distributed, default_arg,
//          |                      | dist_arg, grid_size, last_dim
//  out     | out_valid / out_stall| elem_count, overflow
//  cfg     | APB psel/penable     | process_rank at byte address 0
//
// One dimension descriptor is taken per beat, last dimension first. An
// undistributed dimension needs only the final multiply into the product,
// an evenly split one adds two divides and a cyclic one two divides and
// three multiplies, all on the bit-serial divider or multiplier; a zero
// count or a saturated product skips the final multiply.
// Reset clears the run: the product is one, no zero seen, no saturation.
// The input is stalled while a descriptor is in work; a finished result sits
// in the output register, and only the closing step of a later run waits on it.
//
module darray_local_block_count_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Descriptor input.
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [dlbc_pkg::GSIZE_W-1:0]          global_size,
	input  logic                                  distributed,
	input  logic                                  default_arg,
	input  logic [dlbc_pkg::DARG_W-1:0]           dist_arg,
	input  logic [dlbc_pkg::GRID_W-1:0]           grid_size,
	input  logic                                  last_dim,
	// Result output.
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [dlbc_pkg::PROD_W-1:0]           elem_count,
	output logic                                  overflow,
	// Configuration port.
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [dlbc_pkg::CFG_ADDR_W-1:0]       paddr,
	input  logic [dlbc_pkg::CFG_DATA_W-1:0]       pwdata,
	output logic [dlbc_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                  pready
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_RANK,
		ST_DIV_G,
		ST_MUL_CYC,
		ST_DIV_CYC,
		ST_MUL_START,
		ST_MUL_QD,
		ST_PROD_CHK,
		ST_PROD,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration.
	logic [dlbc_pkg::RANK_W-1:0]   process_rank_q;

	// Descriptor being worked on.
	logic [dlbc_pkg::GSIZE_W-1:0]  gsize_q;
	logic                          dist_q;
	logic                          dflt_q;
	logic [dlbc_pkg::DARG_W-1:0]   darg_q;
	logic [dlbc_pkg::GRID_W-1:0]   grid_q;
	logic                          last_q;

	// Run state.
	logic [dlbc_pkg::RANK_W-1:0]   rank_left_q;
	logic                          run_open_q;
	logic [dlbc_pkg::PROD_W-1:0]   prod_q;
	logic                          saw_zero_q;
	logic                          sat_q;

	// Intermediate values of one dimension.
	logic [dlbc_pkg::GRID_W-1:0]   pcoord_q;
	logic [dlbc_pkg::CYC_W-1:0]    cycle_q;
	logic [dlbc_pkg::GSIZE_W-1:0]  cquot_q;
	logic [dlbc_pkg::GSIZE_W-1:0]  remain_q;
	logic [dlbc_pkg::CYC_W-1:0]    start_q;
	logic [dlbc_pkg::GSIZE_W-1:0]  sub_q;

	// Output register.
	logic                          out_valid_q;
	logic [dlbc_pkg::PROD_W-1:0]   total_q;
	logic                          ovf_q;

	// Serial unit handshake.
	logic                          div_start_q;
	logic                          mul_start_q;
	logic                          div_done;
	logic                          mul_done;
	logic [dlbc_pkg::DIV_N_W-1:0]  div_dividend;
	logic [dlbc_pkg::DIV_D_W-1:0]  div_divisor;
	logic [dlbc_pkg::DIV_N_W-1:0]  div_quot;
	logic [dlbc_pkg::DIV_N_W-1:0]  div_rem;
	logic [dlbc_pkg::MUL_A_W-1:0]  mul_a;
	logic [dlbc_pkg::MUL_B_W-1:0]  mul_b;
	logic [dlbc_pkg::MUL_P_W-1:0]  mul_product;

	logic                          in_accept;
	logic                          cfg_write;
	logic                          out_load;
	logic                          remain_gt;
	logic [dlbc_pkg::GSIZE_W-1:0]  remain_diff;
	logic [dlbc_pkg::GSIZE_W-1:0]  part;
	logic [dlbc_pkg::GSIZE_W-1:0]  cyc_sub;
	logic                          extra_elem;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	// The closing step of a run loads the output register once it is free.
	assign out_load  = (state_q == ST_DONE) && last_q && (!out_valid_q || !out_stall);

	// ------------------------------------------------------------------
	// Configuration port: pready is always high.
	// ------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_rank_q <= '0;
		end else if (cfg_write && paddr[2] == dlbc_pkg::REG_PROCESS_RANK) begin
			process_rank_q <= pwdata[dlbc_pkg::RANK_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == dlbc_pkg::REG_PROCESS_RANK) begin
			prdata = {{(dlbc_pkg::CFG_DATA_W-dlbc_pkg::RANK_W){1'b0}}, process_rank_q};
		end
	end

	// ------------------------------------------------------------------
	// Operand selection for the shared serial units. The operands only
	// need to be right in the cycle the unit is started, which is the
	// first cycle of the matching state.
	// ------------------------------------------------------------------
	always_comb begin
		div_dividend = gsize_q;
		div_divisor  = {{(dlbc_pkg::DIV_D_W-dlbc_pkg::GRID_W){1'b0}}, grid_q};
		case (state_q)
			ST_DIV_RANK: div_dividend = rank_left_q;
			ST_DIV_CYC:  div_divisor  = cycle_q;
			default:     div_dividend = gsize_q;
		endcase
	end

	always_comb begin
		mul_a = {{(dlbc_pkg::MUL_A_W-dlbc_pkg::DARG_W){1'b0}}, darg_q};
		mul_b = darg_q;
		case (state_q)
			ST_MUL_CYC: begin
				mul_b = {{(dlbc_pkg::MUL_B_W-dlbc_pkg::GRID_W){1'b0}}, grid_q};
			end
			ST_MUL_START: begin
				mul_a = {{(dlbc_pkg::MUL_A_W-dlbc_pkg::GRID_W){1'b0}}, pcoord_q};
			end
			ST_MUL_QD: begin
				mul_a = {{(dlbc_pkg::MUL_A_W-dlbc_pkg::GSIZE_W){1'b0}}, cquot_q};
			end
			ST_PROD: begin
				mul_a = prod_q;
				mul_b = sub_q;
			end
			default: begin
				mul_b = darg_q;
			end
		endcase
	end

	dlbc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	dlbc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_product)
	);

	// Even split: coordinates below the remainder own one extra element.
	assign extra_elem = {{(dlbc_pkg::GSIZE_W-dlbc_pkg::GRID_W){1'b0}}, pcoord_q} < div_rem;

	// Cyclic split: the partial cycle at the end gives this process the part
	// of its block that lies below the remainder, at most one whole block.
	// The full cycles give one block each, and that product arrives now.
	assign remain_gt   = {{(dlbc_pkg::CYC_W-dlbc_pkg::GSIZE_W){1'b0}}, remain_q} > start_q;
	assign remain_diff = remain_q - start_q[dlbc_pkg::GSIZE_W-1:0];
	assign part        = !remain_gt ? '0 : ((remain_diff > darg_q) ? darg_q : remain_diff);
	assign cyc_sub     = part + mul_product[dlbc_pkg::GSIZE_W-1:0];

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_open_q  <= 1'b0;
			prod_q      <= {{(dlbc_pkg::PROD_W-1){1'b0}}, 1'b1};
			saw_zero_q  <= 1'b0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						run_open_q <= 1'b1;
						if (distributed) begin
							div_start_q <= 1'b1;
							state_q     <= ST_DIV_RANK;
						end else begin
							state_q <= ST_PROD_CHK;
						end
					end
				end
				ST_DIV_RANK: begin
					if (div_done) begin
						if (dflt_q) begin
							div_start_q <= 1'b1;
							state_q     <= ST_DIV_G;
						end else begin
							mul_start_q <= 1'b1;
							state_q     <= ST_MUL_CYC;
						end
					end
				end
				ST_DIV_G: begin
					if (div_done) begin
						state_q <= ST_PROD_CHK;
					end
				end
				ST_MUL_CYC: begin
					if (mul_done) begin
						div_start_q <= 1'b1;
						state_q     <= ST_DIV_CYC;
					end
				end
				ST_DIV_CYC: begin
					if (div_done) begin
						mul_start_q <= 1'b1;
						state_q     <= ST_MUL_START;
					end
				end
				ST_MUL_START: begin
					if (mul_done) begin
						mul_start_q <= 1'b1;
						state_q     <= ST_MUL_QD;
					end
				end
				ST_MUL_QD: begin
					if (mul_done) begin
						state_q <= ST_PROD_CHK;
					end
				end
				ST_PROD_CHK: begin
					// A zero dimension wins; a saturated product is frozen.
					if (sub_q == '0) begin
						saw_zero_q <= 1'b1;
						state_q    <= ST_DONE;
					end else if (sat_q) begin
						state_q <= ST_DONE;
					end else begin
						mul_start_q <= 1'b1;
						state_q     <= ST_PROD;
					end
				end
				ST_PROD: begin
					if (mul_done) begin
						if (|mul_product[dlbc_pkg::MUL_P_W-1:dlbc_pkg::PROD_W]) begin
							prod_q <= '1;
							sat_q  <= 1'b1;
						end else begin
							prod_q <= mul_product[dlbc_pkg::PROD_W-1:0];
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (!out_valid_q || !out_stall) begin
						run_open_q  <= 1'b0;
						prod_q      <= {{(dlbc_pkg::PROD_W-1){1'b0}}, 1'b1};
						saw_zero_q  <= 1'b0;
						sat_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers of the datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					gsize_q <= global_size;
					dist_q  <= distributed;
					dflt_q  <= default_arg;
					darg_q  <= (dist_arg == '0) ? {{(dlbc_pkg::DARG_W-1){1'b0}}, 1'b1}
						: dist_arg;
					grid_q  <= (grid_size == '0) ? {{(dlbc_pkg::GRID_W-1){1'b0}}, 1'b1}
						: grid_size;
					last_q  <= last_dim;
					sub_q   <= global_size;
					if (!run_open_q) begin
						rank_left_q <= process_rank_q;
					end
				end
			end
			ST_DIV_RANK: begin
				if (div_done) begin
					pcoord_q    <= div_rem[dlbc_pkg::GRID_W-1:0];
					rank_left_q <= div_quot;
				end
			end
			ST_DIV_G: begin
				if (div_done) begin
					sub_q <= div_quot + {{(dlbc_pkg::GSIZE_W-1){1'b0}}, extra_elem};
				end
			end
			ST_MUL_CYC: begin
				if (mul_done) begin
					cycle_q <= mul_product[dlbc_pkg::CYC_W-1:0];
				end
			end
			ST_DIV_CYC: begin
				if (div_done) begin
					cquot_q  <= div_quot;
					remain_q <= div_rem;
				end
			end
			ST_MUL_START: begin
				if (mul_done) begin
					start_q <= mul_product[dlbc_pkg::CYC_W-1:0];
				end
			end
			ST_MUL_QD: begin
				if (mul_done) begin
					sub_q <= cyc_sub;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					total_q <= saw_zero_q ? '0 : prod_q;
					ovf_q   <= !saw_zero_q && sat_q;
				end
			end
			default: begin
				sub_q <= sub_q;
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign elem_count = total_q;
	assign overflow   = ovf_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------

	// A new result only appears as the closing step of a run.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result appeared outside the closing step");

	// A saturated result carries the saturation value.
	a_overflow_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> elem_count == '1)
		else $error("overflow flagged without saturated count");

	// The two serial units are never finishing together.
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_done && mul_done))
		else $error("divider and multiplier finished together");

	// A dimension that skips the divider goes straight to the product check.
	a_undist_path: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && !distributed |=> state_q == ST_PROD_CHK && !dist_q)
		else $error("undistributed dimension took the wrong path");

endmodule
